// ----- design/cwf_pkg.sv -----
`timescale 1ns / 1ps
package cwf_pkg;

  typedef enum logic [4:0] {
    CMD_ADD     = 5'd0,
    CMD_ADC     = 5'd1,
    CMD_SUB     = 5'd2,
    CMD_SBC     = 5'd3,
    CMD_AND     = 5'd4,
    CMD_XOR     = 5'd5,
    CMD_OR      = 5'd6,
    CMD_CP      = 5'd7,
    CMD_INC     = 5'd8,
    CMD_DEC     = 5'd9,
    CMD_SWAP    = 5'd10,
    CMD_RLC     = 5'd11,
    CMD_RL      = 5'd12,
    CMD_RRC     = 5'd13,
    CMD_RR      = 5'd14,
    CMD_SLA     = 5'd15,
    CMD_SRA     = 5'd16,
    CMD_SRL     = 5'd17,
    CMD_BIT     = 5'd18,
    CMD_SET     = 5'd19,
    CMD_RES     = 5'd20,
    CMD_ADD16   = 5'd21,
    CMD_LOAD_A  = 5'd22,
    CMD_LOAD_AF = 5'd23
  } cmd_t;

  typedef struct packed {
    logic z;
    logic n;
    logic h;
    logic c;
  } flags_t;

  // One item as held in the input register.
  typedef struct packed {
    logic [4:0]  command;
    logic [7:0]  operand;
    logic [2:0]  bit_index;
    logic        use_accumulator;
    logic [15:0] word_first;
    logic [15:0] word_second;
  } item_t;

  // Everything the execute logic produces for one item.
  typedef struct packed {
    logic [7:0]  result;
    logic [15:0] result_wide;
    logic [7:0]  acc;
    flags_t      flags;
  } exec_t;

endpackage

// ----- design/cwf_alu.sv -----
`timescale 1ns / 1ps
module cwf_alu (
  input  cwf_pkg::item_t  item,
  input  logic [7:0]      acc,
  input  cwf_pkg::flags_t flags,
  output cwf_pkg::exec_t  exec
);
  import cwf_pkg::*;

  logic [7:0]  a;
  logic [7:0]  b;
  logic [7:0]  x;
  logic        cin;
  logic        t;
  logic [8:0]  sum9;
  logic [4:0]  sum5;
  logic [8:0]  diff9;
  logic [4:0]  diff5;
  logic [16:0] sum17;
  logic [12:0] sum13;
  logic [7:0]  mask;
  logic [7:0]  res;
  logic [7:0]  acc_next;
  flags_t      flags_next;
  logic [15:0] wide;

  assign a    = acc;
  assign b    = item.operand;
  assign x    = item.use_accumulator ? acc : item.operand;
  assign cin  = flags.c;
  assign t    = ((item.command == CMD_ADC) || (item.command == CMD_SBC)) ? cin : 1'b0;
  assign sum9  = {1'b0, a} + {1'b0, b} + {8'b0, t};
  assign sum5  = {1'b0, a[3:0]} + {1'b0, b[3:0]} + {4'b0, t};
  assign diff9 = {1'b0, a} - {1'b0, b} - {8'b0, t};
  assign diff5 = {1'b0, a[3:0]} - {1'b0, b[3:0]} - {4'b0, t};
  assign sum17 = {1'b0, item.word_first} + {1'b0, item.word_second};
  assign sum13 = {1'b0, item.word_first[11:0]} + {1'b0, item.word_second[11:0]};
  assign mask  = 8'b1 << item.bit_index;

  always_comb begin
    res        = 8'd0;
    wide       = 16'd0;
    acc_next   = acc;
    flags_next = flags;
    unique case (item.command)
      CMD_ADD, CMD_ADC: begin
        res        = sum9[7:0];
        flags_next = '{z: (sum9[7:0] == 8'd0), n: 1'b0, h: sum5[4], c: sum9[8]};
        acc_next   = res;
      end
      CMD_SUB, CMD_SBC, CMD_CP: begin
        res        = diff9[7:0];
        flags_next = '{z: (diff9[7:0] == 8'd0), n: 1'b1, h: diff5[4], c: diff9[8]};
        if (item.command != CMD_CP) begin
          acc_next = res;
        end
      end
      CMD_AND: begin
        res        = a & b;
        flags_next = '{z: ((a & b) == 8'd0), n: 1'b0, h: 1'b1, c: 1'b0};
        acc_next   = res;
      end
      CMD_XOR: begin
        res        = a ^ b;
        flags_next = '{z: ((a ^ b) == 8'd0), n: 1'b0, h: 1'b0, c: 1'b0};
        acc_next   = res;
      end
      CMD_OR: begin
        res        = a | b;
        flags_next = '{z: ((a | b) == 8'd0), n: 1'b0, h: 1'b0, c: 1'b0};
        acc_next   = res;
      end
      CMD_INC: begin
        res        = x + 8'd1;
        flags_next = '{z: (res == 8'd0), n: 1'b0, h: (res[3:0] == 4'd0), c: cin};
      end
      CMD_DEC: begin
        res        = x - 8'd1;
        flags_next = '{z: (res == 8'd0), n: 1'b1, h: (x[3:0] == 4'd0), c: cin};
      end
      CMD_SWAP: begin
        res        = {x[3:0], x[7:4]};
        flags_next = '{z: (x == 8'd0), n: 1'b0, h: 1'b0, c: 1'b0};
      end
      CMD_RLC: begin
        res        = {x[6:0], x[7]};
        flags_next = '{z: (x == 8'd0), n: 1'b0, h: 1'b0, c: x[7]};
      end
      CMD_RL: begin
        res        = {x[6:0], cin};
        flags_next = '{z: (res == 8'd0), n: 1'b0, h: 1'b0, c: x[7]};
      end
      CMD_RRC: begin
        res        = {x[0], x[7:1]};
        flags_next = '{z: (x == 8'd0), n: 1'b0, h: 1'b0, c: x[0]};
      end
      CMD_RR: begin
        res        = {cin, x[7:1]};
        flags_next = '{z: (res == 8'd0), n: 1'b0, h: 1'b0, c: x[0]};
      end
      CMD_SLA: begin
        res        = {x[6:0], 1'b0};
        flags_next = '{z: (res == 8'd0), n: 1'b0, h: 1'b0, c: x[7]};
      end
      CMD_SRA: begin
        res        = {x[7], x[7:1]};
        flags_next = '{z: (res == 8'd0), n: 1'b0, h: 1'b0, c: x[0]};
      end
      CMD_SRL: begin
        res        = {1'b0, x[7:1]};
        flags_next = '{z: (res == 8'd0), n: 1'b0, h: 1'b0, c: x[0]};
      end
      CMD_BIT: begin
        res        = x;
        flags_next = '{z: ((x & mask) == 8'd0), n: 1'b0, h: 1'b1, c: cin};
      end
      CMD_SET: begin
        res = x | mask;
      end
      CMD_RES: begin
        res = x & ~mask;
      end
      CMD_ADD16: begin
        wide       = sum17[15:0];
        flags_next = '{z: flags.z, n: 1'b0, h: sum13[12], c: sum17[16]};
      end
      CMD_LOAD_A: begin
        res      = b;
        acc_next = b;
      end
      CMD_LOAD_AF: begin
        res        = item.word_second[15:8];
        acc_next   = item.word_second[15:8];
        flags_next = flags_t'(item.word_second[7:4]);
      end
      default: begin
        res = 8'd0;
      end
    endcase
    // Unary ops write back only when aimed at the accumulator.
    if ((item.command >= CMD_INC) && (item.command <= CMD_RES) && item.use_accumulator) begin
      acc_next = res;
    end
  end

  assign exec = '{result: res, result_wide: wide, acc: acc_next, flags: flags_next};

endmodule

// ----- design/cpu_alu_with_flags_top.sv -----
`timescale 1ns / 1ps
// 8-bit CPU ALU with accumulator and Z/N/H/C flags.
// Input channel: in_valid / in_stall with command, operand, bit_index,
//   use_accumulator, word_first and word_second. A transfer happens on a
//   rising edge with in_valid high and in_stall low.
// Output channel: out_valid / out_stall with result, result_wide,
//   accumulator and the four flags, one result transfer per input transfer.
// The input register takes the item, then the execute logic loads the result
//   register together with the accumulator and flag state.
// Throughput: one item per cycle while the receiver does not stall. The
//   accumulator and flags are written in the same cycle as the result
//   register, so the next item in the input register always executes on
//   up-to-date state without forwarding.
// Reset (rst, synchronous): empties both stages, clears accumulator and flags.
// When the receiver stalls, the result register holds; the input register
//   still takes one more item, and in_stall rises only when both stages are
//   full.
module cpu_alu_with_flags_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [4:0]  command,
  input  logic [7:0]  operand,
  input  logic [2:0]  bit_index,
  input  logic        use_accumulator,
  input  logic [15:0] word_first,
  input  logic [15:0] word_second,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  result,
  output logic [15:0] result_wide,
  output logic [7:0]  accumulator,
  output logic        zero_flag,
  output logic        subtract_flag,
  output logic        half_flag,
  output logic        carry_flag
);
  import cwf_pkg::*;

  // Input register
  logic   item_valid;
  item_t  item;
  // Architectural state
  logic [7:0] acc;
  flags_t     flags;
  // Result register
  exec_t  out_data;
  exec_t  exec;

  logic out_free;
  logic advance;
  logic in_take;

  assign out_free = !out_valid || !out_stall;
  assign advance  = item_valid && out_free;
  assign in_stall = item_valid && !out_free;
  assign in_take  = in_valid && !in_stall;

  cwf_alu u_alu (
    .item  (item),
    .acc   (acc),
    .flags (flags),
    .exec  (exec)
  );

  // Input stage: refill whenever the item moves on or the slot is empty.
  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (!in_stall) begin
      item_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      item <= '{command: command, operand: operand, bit_index: bit_index,
                use_accumulator: use_accumulator, word_first: word_first,
                word_second: word_second};
    end
  end

  // Commit state only when the item lands in the result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      acc   <= 8'd0;
      flags <= '0;
    end else if (advance) begin
      acc   <= exec.acc;
      flags <= exec.flags;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data <= exec;
    end
  end

  assign result        = out_data.result;
  assign result_wide   = out_data.result_wide;
  assign accumulator   = out_data.acc;
  assign zero_flag     = out_data.flags.z;
  assign subtract_flag = out_data.flags.n;
  assign half_flag     = out_data.flags.h;
  assign carry_flag    = out_data.flags.c;

  // A pending result always reflects the committed state.
  a_out_matches_state: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (accumulator == acc) && (out_data.flags == flags))
    else $error("result register disagrees with accumulator/flag state");

  // Back-pressure only when the input register is occupied.
  a_stall_needs_item: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> item_valid)
    else $error("input stalled with empty input register");

  // A blocked item stays in the input register.
  a_item_held: assert property (@(posedge clk) disable iff (rst)
    (item_valid && !out_free) |=> item_valid)
    else $error("item dropped while result register was blocked");

  // State comes out of reset cleared.
  a_reset_state: assert property (@(posedge clk)
    $past(rst) |-> (acc == 8'd0) && (flags == '0) && !out_valid && !item_valid)
    else $error("state not cleared by reset");

endmodule

// ----- bench/alu_outcome_checker.sv -----
`timescale 1ns / 1ps
// Watches both channels of the ALU, keeps its own accumulator and flags,
// predicts every result at input transfer and compares in order.
module alu_outcome_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [4:0]  command,
  input  logic [7:0]  operand,
  input  logic [2:0]  bit_index,
  input  logic        use_accumulator,
  input  logic [15:0] word_first,
  input  logic [15:0] word_second,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [7:0]  result,
  input  logic [15:0] result_wide,
  input  logic [7:0]  accumulator,
  input  logic        zero_flag,
  input  logic        subtract_flag,
  input  logic        half_flag,
  input  logic        carry_flag,
  output int          fail_count,
  output int          pending
);
  import cwf_pkg::*;

  logic [7:0] acc_model;
  flags_t     flags_model;
  exec_t      outcomes[$];
  int         results_seen;

  initial begin
    fail_count   = 0;
    pending      = 0;
    results_seen = 0;
    acc_model    = 8'h00;
    flags_model  = '0;
  end

  task automatic report_mismatch(input string msg);
    $display("%0t ns: result %0d: %s", $time, results_seen, msg);
    fail_count++;
  endtask

  task automatic compare_field(input string name, input logic [15:0] got,
                               input logic [15:0] want);
    if (got !== want)
      report_mismatch($sformatf("%s is %0h, expected %0h", name, got, want));
  endtask

  // Advance the model state by one item and return what the block must show.
  function automatic exec_t compute_alu_outcome(input item_t it);
    exec_t      o;
    logic [7:0] a;
    logic [7:0] b;
    logic [7:0] x;
    logic [7:0] r;
    logic       cin;
    int         t;
    int         sum;
    a   = acc_model;
    b   = it.operand;
    cin = flags_model.c;
    x   = it.use_accumulator ? a : b;
    r   = 8'h00;
    o.result_wide = 16'h0000;
    case (it.command)
      CMD_ADD, CMD_ADC: begin
        t   = (it.command == CMD_ADC) ? int'(cin) : 0;
        sum = int'(a) + int'(b) + t;
        r   = sum[7:0];
        flags_model = {r == 8'h00, 1'b0, int'(a[3:0]) + int'(b[3:0]) + t > 15, sum > 255};
        acc_model = r;
      end
      CMD_SUB, CMD_SBC, CMD_CP: begin
        t = (it.command == CMD_SBC) ? int'(cin) : 0;
        r = 8'(int'(a) - int'(b) - t);
        flags_model = {r == 8'h00, 1'b1, int'(a[3:0]) < int'(b[3:0]) + t,
                       int'(a) < int'(b) + t};
        if (it.command != CMD_CP) acc_model = r;
      end
      CMD_AND: begin
        r = a & b;
        flags_model = {r == 8'h00, 1'b0, 1'b1, 1'b0};
        acc_model = r;
      end
      CMD_XOR: begin
        r = a ^ b;
        flags_model = {r == 8'h00, 3'b000};
        acc_model = r;
      end
      CMD_OR: begin
        r = a | b;
        flags_model = {r == 8'h00, 3'b000};
        acc_model = r;
      end
      CMD_INC: begin
        r = x + 8'd1;
        flags_model = {r == 8'h00, 1'b0, r[3:0] == 4'h0, cin};
      end
      CMD_DEC: begin
        r = x - 8'd1;
        flags_model = {r == 8'h00, 1'b1, x[3:0] == 4'h0, cin};
      end
      CMD_SWAP: begin
        r = {x[3:0], x[7:4]};
        flags_model = {r == 8'h00, 3'b000};
      end
      CMD_RLC: begin
        r = {x[6:0], x[7]};
        flags_model = {r == 8'h00, 2'b00, x[7]};
      end
      CMD_RL: begin
        r = {x[6:0], cin};
        flags_model = {r == 8'h00, 2'b00, x[7]};
      end
      CMD_RRC: begin
        r = {x[0], x[7:1]};
        flags_model = {r == 8'h00, 2'b00, x[0]};
      end
      CMD_RR: begin
        r = {cin, x[7:1]};
        flags_model = {r == 8'h00, 2'b00, x[0]};
      end
      CMD_SLA: begin
        r = {x[6:0], 1'b0};
        flags_model = {r == 8'h00, 2'b00, x[7]};
      end
      CMD_SRA: begin
        r = {x[7], x[7:1]};
        flags_model = {r == 8'h00, 2'b00, x[0]};
      end
      CMD_SRL: begin
        r = {1'b0, x[7:1]};
        flags_model = {r == 8'h00, 2'b00, x[0]};
      end
      CMD_BIT: begin
        r = x;
        flags_model = {~x[it.bit_index], 1'b0, 1'b1, cin};
      end
      CMD_SET: r = x | (8'h01 << it.bit_index);
      CMD_RES: r = x & ~(8'h01 << it.bit_index);
      CMD_ADD16: begin
        sum = int'(it.word_first) + int'(it.word_second);
        o.result_wide = sum[15:0];
        flags_model = {flags_model.z, 1'b0,
                       int'(it.word_first[11:0]) + int'(it.word_second[11:0]) > 4095,
                       sum > 65535};
      end
      CMD_LOAD_A: begin
        r = b;
        acc_model = b;
      end
      CMD_LOAD_AF: begin
        acc_model   = it.word_second[15:8];
        r           = acc_model;
        flags_model = it.word_second[7:4];
      end
      default: ;
    endcase
    if (it.command >= CMD_INC && it.command <= CMD_RES && it.use_accumulator)
      acc_model = r;
    o.result = r;
    o.acc    = acc_model;
    o.flags  = flags_model;
    return o;
  endfunction

  always @(posedge clk) begin : watch
    exec_t want;
    item_t it;
    if (rst) begin
      acc_model   = 8'h00;
      flags_model = '0;
      outcomes.delete();
    end else begin
      if (out_valid && !out_stall) begin
        results_seen++;
        if (outcomes.size() == 0) begin
          report_mismatch("result transfer with nothing expected");
        end else begin
          want = outcomes.pop_front();
          compare_field("result", 16'(result), 16'(want.result));
          compare_field("result_wide", result_wide, want.result_wide);
          compare_field("accumulator", 16'(accumulator), 16'(want.acc));
          compare_field("zero_flag", 16'(zero_flag), 16'(want.flags.z));
          compare_field("subtract_flag", 16'(subtract_flag), 16'(want.flags.n));
          compare_field("half_flag", 16'(half_flag), 16'(want.flags.h));
          compare_field("carry_flag", 16'(carry_flag), 16'(want.flags.c));
        end
      end
      if (in_valid && !in_stall) begin
        it = {command, operand, bit_index, use_accumulator, word_first, word_second};
        outcomes.push_back(compute_alu_outcome(it));
      end
    end
    pending <= outcomes.size();
  end

endmodule

// ----- bench/tb.sv -----
`timescale 1ns / 1ps
// Stimulus and verdict for the ALU. Prediction and comparison live in
// alu_outcome_checker; this module only drives both channels.
module tb;
  import cwf_pkg::*;

  // Command codes the block does not decode; they must change nothing.
  localparam logic [4:0] CMD_UNUSED_LO = 5'd24;
  localparam logic [4:0] CMD_UNUSED_HI = 5'd31;
  localparam int RANDOM_PER_PHASE = 235;
  localparam int CYCLE_LIMIT      = 200000;
  localparam int LONG_HOLD        = 60;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [4:0]  command = '0;
  logic [7:0]  operand = '0;
  logic [2:0]  bit_index = '0;
  logic        use_accumulator = 1'b0;
  logic [15:0] word_first = '0;
  logic [15:0] word_second = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [7:0]  result;
  logic [15:0] result_wide;
  logic [7:0]  accumulator;
  logic        zero_flag;
  logic        subtract_flag;
  logic        half_flag;
  logic        carry_flag;

  int fail_count;
  int pending;
  int send_gap_pct = 0;
  int recv_stall_pct = 0;
  int hold_left = 0;
  int cycle_count = 0;

  always #6 clk = ~clk;

  cpu_alu_with_flags_top dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .command(command), .operand(operand), .bit_index(bit_index),
    .use_accumulator(use_accumulator),
    .word_first(word_first), .word_second(word_second),
    .out_valid(out_valid), .out_stall(out_stall),
    .result(result), .result_wide(result_wide), .accumulator(accumulator),
    .zero_flag(zero_flag), .subtract_flag(subtract_flag),
    .half_flag(half_flag), .carry_flag(carry_flag)
  );

  alu_outcome_checker u_checker (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .command(command), .operand(operand), .bit_index(bit_index),
    .use_accumulator(use_accumulator),
    .word_first(word_first), .word_second(word_second),
    .out_valid(out_valid), .out_stall(out_stall),
    .result(result), .result_wide(result_wide), .accumulator(accumulator),
    .zero_flag(zero_flag), .subtract_flag(subtract_flag),
    .half_flag(half_flag), .carry_flag(carry_flag),
    .fail_count(fail_count), .pending(pending)
  );

  // Hard stop in case the block hangs or drops a transfer.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Receiver side: stall at random, or hold off for a long stretch when the
  // stimulus asks for one, so that both pipeline stages fill and in_stall rises.
  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left = hold_left - 1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // Offer one item; called at a falling edge, returns at the falling edge
  // after its transfer. Idle cycles go in front so valid never drops mid-offer.
  task automatic offer(input logic [4:0] cmd, input logic [7:0] op,
                       input logic [2:0] bidx, input logic use_acc,
                       input logic [15:0] w1, input logic [15:0] w2);
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid        <= 1'b1;
    command         <= cmd;
    operand         <= op;
    bit_index       <= bidx;
    use_accumulator <= use_acc;
    word_first      <= w1;
    word_second     <= w2;
    // Hold the payload until the transfer happens.
    do @(posedge clk); while (!(in_valid && !in_stall));
    @(negedge clk);
  endtask

  // Bias bytes toward the carry and sign boundaries.
  function automatic logic [7:0] pick_byte();
    case ($urandom_range(7))
      0: return 8'h00;
      1: return 8'hff;
      2: return 8'h80;
      3: return 8'h7f;
      4: return 8'h0f;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  function automatic logic [15:0] pick_word();
    case ($urandom_range(5))
      0: return 16'h0000;
      1: return 16'hffff;
      2: return 16'h0fff;
      default: return 16'($urandom_range(65535));
    endcase
  endfunction

  task automatic offer_random_item();
    logic [4:0] cmd;
    if ($urandom_range(19) == 0)
      cmd = 5'($urandom_range(CMD_UNUSED_HI, CMD_UNUSED_LO));
    else
      cmd = 5'($urandom_range(CMD_LOAD_AF));
    offer(cmd, pick_byte(), 3'($urandom_range(7)), 1'($urandom_range(1)),
          pick_word(), pick_word());
  endtask

  initial begin
    // Hold reset, then release it on a falling edge.
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    send_gap_pct   = 16;
    recv_stall_pct = 61;

    // Directed pass: every command, carry and half-carry boundaries,
    // both unary targets, bit tests at both ends, loads and undecoded codes.
    offer(CMD_LOAD_A,  8'h0f, 3'd0, 1'b0, 16'h0000, 16'h0000);
    offer(CMD_ADD,     8'h01, 3'd0, 1'b0, 16'h0000, 16'h0000);
    offer(CMD_ADD,     8'hf0, 3'd0, 1'b0, 16'h0000, 16'h0000);
    offer(CMD_ADC,     8'hff, 3'd0, 1'b0, 16'h0000, 16'h0000);
    offer(CMD_SUB,     8'h01, 3'd0, 1'b0, 16'h0000, 16'h0000);
    offer(CMD_SBC,     8'hfe, 3'd0, 1'b0, 16'h0000, 16'h0000);
    offer(CMD_CP,      8'h00, 3'd0, 1'b0, 16'h0000, 16'h0000);
    offer(CMD_AND,     8'h0f, 3'd0, 1'b0, 16'h0000, 16'h0000);
    offer(CMD_XOR,     8'hff, 3'd0, 1'b0, 16'h0000, 16'h0000);
    offer(CMD_OR,      8'h00, 3'd0, 1'b0, 16'h0000, 16'h0000);
    offer(CMD_INC,     8'hff, 3'd0, 1'b0, 16'h0000, 16'h0000);
    offer(CMD_DEC,     8'h10, 3'd0, 1'b1, 16'h0000, 16'h0000);
    offer(CMD_SWAP,    8'ha5, 3'd0, 1'b1, 16'h0000, 16'h0000);
    offer(CMD_RLC,     8'h80, 3'd0, 1'b0, 16'h0000, 16'h0000);
    offer(CMD_RL,      8'h80, 3'd0, 1'b0, 16'h0000, 16'h0000);
    offer(CMD_RRC,     8'h01, 3'd0, 1'b0, 16'h0000, 16'h0000);
    offer(CMD_RR,      8'h01, 3'd0, 1'b1, 16'h0000, 16'h0000);
    offer(CMD_SLA,     8'hff, 3'd0, 1'b0, 16'h0000, 16'h0000);
    offer(CMD_SRA,     8'h81, 3'd0, 1'b0, 16'h0000, 16'h0000);
    offer(CMD_SRL,     8'hff, 3'd0, 1'b1, 16'h0000, 16'h0000);
    offer(CMD_BIT,     8'h80, 3'd7, 1'b0, 16'h0000, 16'h0000);
    offer(CMD_BIT,     8'h80, 3'd0, 1'b0, 16'h0000, 16'h0000);
    offer(CMD_SET,     8'h00, 3'd7, 1'b1, 16'h0000, 16'h0000);
    offer(CMD_RES,     8'hff, 3'd0, 1'b0, 16'h0000, 16'h0000);
    offer(CMD_ADD16,   8'h00, 3'd0, 1'b0, 16'hffff, 16'h0001);
    offer(CMD_ADD16,   8'h00, 3'd0, 1'b0, 16'h0fff, 16'h0001);
    offer(CMD_LOAD_AF, 8'h00, 3'd0, 1'b0, 16'h0000, 16'hffff);
    offer(CMD_UNUSED_LO, 8'hff, 3'd7, 1'b1, 16'hffff, 16'hffff);
    offer(CMD_UNUSED_HI, 8'h00, 3'd0, 1'b0, 16'h0000, 16'h00f0);

    // Random pass in three idle mixes: slow receiver, slow sender, none.
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin send_gap_pct = 16; recv_stall_pct = 61; end
        1: begin send_gap_pct = 61; recv_stall_pct = 16; end
        default: begin
          send_gap_pct   = 0;
          recv_stall_pct = 0;
          // Drop valid so the last item is not offered again while waiting.
          in_valid <= 1'b0;
          // Long receiver hold-off while items keep coming.
          @(posedge clk);
          hold_left = LONG_HOLD;
          @(negedge clk);
        end
      endcase
      for (int i = 0; i < RANDOM_PER_PHASE; i++)
        offer_random_item();
    end
    in_valid <= 1'b0;

    // Drain, then keep watching so the pipeline can show any extra result.
    while (pending != 0) @(posedge clk);
    repeat (6) @(posedge clk);

    if (fail_count == 0 && pending == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule
